// ===== rtl/dlps_pkg.sv =====
// ----------------------------------------------------------------------------
// dlps_pkg: shared types and constants for the delay-line pitch shifter
// Register codes, sequencer states, multiplier operations and fixed widths.
// ----------------------------------------------------------------------------
package dlps_pkg;

    // defaults for the top-level parameters
    localparam int DELAY_DEPTH_DEF  = 8192;
    localparam int SAMPLE_WIDTH_DEF = 24;

    // fixed field widths
    localparam int STEP_W     = 18;   // read_step, signed Q16
    localparam int MIX_W      = 16;   // mix_gain, unsigned Q1.15
    localparam int DELAY_W    = 13;   // base_delay, samples
    localparam int OFF_W      = 30;   // read offset, signed Q16
    localparam int FRAC_W     = 16;   // fractional bits of offset / read point
    localparam int GAIN_W     = 17;   // gain operand, holds 0..32768
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam int MIX_ONE    = 32768;  // unity in Q1.15
    localparam int MIX_SHIFT  = 15;
    localparam int ROUND_HALF = 16384;
    localparam int BD_RESET   = 2400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READ_STEP  = 2'd0,
        CFG_MIX_GAIN   = 2'd1,
        CFG_BASE_DELAY = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP,
        S_RD1,
        S_RD2,
        S_DIFF,
        S_WET,
        S_MIX,
        S_SUM,
        S_OUT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_INTERP,
        MUL_DRY,
        MUL_WET
    } t_mul_op;

    typedef struct packed {
        logic    en;
        t_mul_op op;
    } t_mul_ctl;

endpackage

// ===== rtl/dlps_mul.sv =====
// ----------------------------------------------------------------------------
// dlps_mul: shared registered multiplier
// Picks one of three operand pairs and registers the signed product.
// ----------------------------------------------------------------------------
module dlps_mul
    import dlps_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  t_mul_ctl                            i_ctl,
    input  logic signed [SAMPLE_WIDTH:0]        i_diff,      // b - a
    input  logic        [FRAC_W-1:0]            i_frac,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_dry,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_wet,
    input  logic        [GAIN_W-1:0]            i_gain,      // wet gain
    input  logic        [GAIN_W-1:0]            i_dry_gain,  // 1 - gain
    output logic signed [SAMPLE_WIDTH+GAIN_W:0] o_prod
);

    localparam int PW = SAMPLE_WIDTH + GAIN_W + 1;

    logic signed [SAMPLE_WIDTH:0] w_a;
    logic signed [GAIN_W-1:0]     w_b;
    logic signed [PW-1:0]         r_prod;

    always_comb begin
        unique case (i_ctl.op)
            MUL_INTERP: begin
                w_a = i_diff;
                w_b = $signed({1'b0, i_frac});
            end
            MUL_DRY: begin
                w_a = {i_dry[SAMPLE_WIDTH-1], i_dry};
                w_b = $signed(i_dry_gain);
            end
            MUL_WET: begin
                w_a = {i_wet[SAMPLE_WIDTH-1], i_wet};
                w_b = $signed(i_gain);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= PW'(w_a * w_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/delay_line_pitch_shifter.sv =====
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter: stereo delay-line pitch shifter
// Circular delay store, fractional read with linear interpolation, dry/wet
// blend, all on one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                     payload (lsb first)
//  s_axis    in   s_axis_tvalid/s_axis_tready   left_in, right_in
//  m_axis    out  m_axis_tvalid/m_axis_tready   left_out, right_out
//  cfg       in   i_cfg_we (no back-pressure)   i_cfg_addr, i_cfg_data
//
//  The read point is first brought into the store by +/-DELAY_DEPTH corrections
//  (at most 2 at the default depth, at most 12 at 1024). One shared multiplier
//  makes three products per channel.
//  Reset (sync, active low) clears sequencer, write index, offset, config to
//  reset values. No clearing pass: the store is tracked by a fill flag, entries
//  not yet written since reset read as zero.
//  s_axis_tready is high only while idle; a finished frame may wait in the
//  output register while the next frame is already taken and worked on.
// ----------------------------------------------------------------------------
module delay_line_pitch_shifter
    import dlps_pkg::*;
#(
    parameter int DELAY_DEPTH  = DELAY_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // slave side
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // fields from bit 0: left_in, right_in, zero pad to bytes
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    // master side
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // fields from bit 0: left_out, right_out, zero pad to bytes
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    // configuration writes
    input  logic                                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                        i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]                       i_cfg_data
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int TW   = ((2*SW+7)/8)*8;
    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int IW   = ((AW > 14) ? AW : 14) + 3;   // signed read index
    localparam int PW   = SW + GAIN_W + 1;              // product width
    localparam int ACW  = PW + 1;                       // accumulator width
    localparam int SUMW = OFF_W + 1;                    // offset update sum
    localparam int OIW  = OFF_W - FRAC_W;               // integer bits of offset

    localparam logic signed [IW-1:0] DEPTH_S = IW'(DELAY_DEPTH);
    localparam logic [AW-1:0]        LAST_IX = AW'(DELAY_DEPTH - 1);

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic signed [STEP_W-1:0]  r_step;
    logic        [MIX_W-1:0]   r_mix;
    logic        [DELAY_W-1:0] r_bd;

    logic        [AW-1:0]      r_wi;     // write index
    logic                      r_full;   // store has wrapped once since reset
    logic signed [OFF_W-1:0]   r_off;    // read offset, Q16

    logic signed [IW-1:0]      r_idx;    // integer read point, being reduced
    logic        [FRAC_W-1:0]  r_frac;
    logic                      r_a_ok;
    logic                      r_b_ok;
    logic                      r_ch;     // 0 left, 1 right

    logic [2*SW-1:0]           r_dry;
    logic [2*SW-1:0]           r_ent_a;
    logic [2*SW-1:0]           r_rd;
    logic signed [SW-1:0]      r_wet;
    logic signed [ACW-1:0]     r_acc;
    logic [SW-1:0]             r_res_l;
    logic [SW-1:0]             r_res_r;

    logic                      r_ovalid;
    logic [TW-1:0]             r_otdata;

    // delay store, both channels side by side
    logic [2*SW-1:0]           mem [DELAY_DEPTH];

    // ---------------- control ----------------
    logic          w_in_acc;
    logic          w_out_free;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_i1;
    logic [AW-1:0] w_i2;
    t_mul_ctl      w_mul;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_i1       = r_idx[AW-1:0];
    assign w_i2       = (w_i1 == LAST_IX) ? '0 : w_i1 + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_WRAP;
            S_WRAP: begin
                if (!r_idx[IW-1] && r_idx < DEPTH_S) n_state = S_RD1;
            end
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_DIFF;
            S_DIFF: n_state = S_WET;
            S_WET:  n_state = S_MIX;
            S_MIX:  n_state = S_SUM;
            S_SUM:  n_state = S_OUT;
            S_OUT:  n_state = r_ch ? S_DONE : S_DIFF;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        w_rd_en       = 1'b0;
        w_rd_addr     = w_i1;
        w_mul.en      = 1'b0;
        w_mul.op      = MUL_INTERP;
        unique case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_RD1:  w_rd_en = 1'b1;
            S_RD2: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_i2;
            end
            S_DIFF: w_mul.en = 1'b1;
            S_WET: begin
                w_mul.en = 1'b1;
                w_mul.op = MUL_DRY;
            end
            S_MIX: begin
                w_mul.en = 1'b1;
                w_mul.op = MUL_WET;
            end
            default: ;
        endcase
    end

    // ---------------- datapath ----------------
    logic signed [SW-1:0]     w_a_s;
    logic signed [SW-1:0]     w_b_s;
    logic signed [SW-1:0]     w_dry_s;
    logic signed [SW:0]       w_diff;
    logic        [GAIN_W-1:0] w_gain;
    logic        [GAIN_W-1:0] w_dry_gain;
    logic signed [PW-1:0]     w_prod;
    logic signed [PW-1:0]     w_wet_full;
    logic signed [ACW-1:0]    w_shift;
    logic                     w_fits;
    logic [SW-1:0]            w_sat;

    assign w_a_s   = r_ch ? r_ent_a[2*SW-1:SW] : r_ent_a[SW-1:0];
    assign w_b_s   = !r_b_ok ? '0 : (r_ch ? r_rd[2*SW-1:SW] : r_rd[SW-1:0]);
    assign w_dry_s = r_ch ? r_dry[2*SW-1:SW] : r_dry[SW-1:0];
    assign w_diff  = {w_b_s[SW-1], w_b_s} - {w_a_s[SW-1], w_a_s};

    // mix gain above unity is held at unity
    assign w_gain     = (r_mix > MIX_W'(MIX_ONE)) ? GAIN_W'(MIX_ONE) : {1'b0, r_mix};
    assign w_dry_gain = GAIN_W'(MIX_ONE) - w_gain;

    dlps_mul #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mul (
        .i_clk      (i_clk),
        .i_ctl      (w_mul),
        .i_diff     (w_diff),
        .i_frac     (r_frac),
        .i_dry      (w_dry_s),
        .i_wet      (r_wet),
        .i_gain     (w_gain),
        .i_dry_gain (w_dry_gain),
        .o_prod     (w_prod)
    );

    // wet = a + floor((b - a) * frac / 2^16)
    assign w_wet_full = PW'(w_a_s) + (w_prod >>> FRAC_W);

    // rounding already added in the accumulator; saturate to sample width
    assign w_shift = r_acc >>> MIX_SHIFT;
    assign w_fits  = (&w_shift[ACW-1:SW-1]) || !(|w_shift[ACW-1:SW-1]);
    assign w_sat   = w_fits ? w_shift[SW-1:0]
                   : (w_shift[ACW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

    // offset update: advance, then jump to the opposite bound when outside
    logic signed [SUMW-1:0] w_off_sum;
    logic signed [SUMW-1:0] w_bound;
    logic signed [SUMW-1:0] w_off_next;

    assign w_off_sum = SUMW'(r_off) + SUMW'(r_step);
    assign w_bound   = $signed({{(SUMW-DELAY_W-MIX_SHIFT){1'b0}}, r_bd, {MIX_SHIFT{1'b0}}});

    always_comb begin
        if (w_off_sum > w_bound) begin
            w_off_next = -w_bound;
        end else if (w_off_sum < -w_bound) begin
            w_off_next = w_bound;
        end else begin
            w_off_next = w_off_sum;
        end
    end

    // store: write on accept, registered read
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            mem[r_wi] <= s_axis_tdata[2*SW-1:0];
        end
        if (w_rd_en) begin
            r_rd <= mem[w_rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_mix    <= '0;
            r_bd     <= DELAY_W'(BD_RESET);
            r_wi     <= '0;
            r_full   <= 1'b0;
            r_off    <= '0;
            r_ovalid <= 1'b0;
            r_ch     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_READ_STEP:  r_step <= $signed(i_cfg_data[STEP_W-1:0]);
                    CFG_MIX_GAIN:   r_mix  <= i_cfg_data[MIX_W-1:0];
                    CFG_BASE_DELAY: r_bd   <= i_cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end

            // a new result replaces one leaving in the same cycle
            if (r_state == S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            if (w_in_acc) begin
                r_ch <= 1'b0;
            end
            if (r_state == S_OUT) begin
                r_ch <= 1'b1;
            end

            if (r_state == S_DONE && w_out_free) begin
                r_off    <= w_off_next[OFF_W-1:0];
                if (r_wi == LAST_IX) begin
                    r_wi   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wi <= r_wi + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_dry  <= s_axis_tdata[2*SW-1:0];
                r_frac <= r_off[FRAC_W-1:0];
                r_idx  <= $signed({{(IW-AW){1'b0}}, r_wi})
                        - $signed({{(IW-DELAY_W){1'b0}}, r_bd})
                        + $signed({{(IW-OIW){r_off[OFF_W-1]}}, r_off[OFF_W-1:FRAC_W]});
            end
            S_WRAP: begin
                if (r_idx[IW-1]) begin
                    r_idx <= r_idx + DEPTH_S;
                end else if (r_idx >= DEPTH_S) begin
                    r_idx <= r_idx - DEPTH_S;
                end
            end
            S_RD1: r_a_ok <= r_full || (w_i1 <= r_wi);
            S_RD2: begin
                r_b_ok  <= r_full || (w_i2 <= r_wi);
                r_ent_a <= r_a_ok ? r_rd : '0;
            end
            S_WET:  r_wet <= w_wet_full[SW-1:0];
            S_MIX:  r_acc <= ACW'(w_prod);
            S_SUM:  r_acc <= r_acc + ACW'(w_prod) + ACW'(ROUND_HALF);
            S_OUT: begin
                if (r_ch) begin
                    r_res_r <= w_sat;
                end else begin
                    r_res_l <= w_sat;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_otdata <= TW'({r_res_r, r_res_l});
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otdata;

endmodule

// ===== rtl/dlps_checker.sv =====
// ----------------------------------------------------------------------------
// dlps_checker: port-level checks for the pitch shifter
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module dlps_checker
    import dlps_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    // no result survives a reset
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one frame at a time: intake closes after a transaction
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second frame taken while busy");

    // a result never appears the cycle after its frame is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared too early");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind delay_line_pitch_shifter dlps_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dlps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
